// ===== hdl/cal_pkg.sv =====
// cal_pkg: shared constants, request kinds and the broadcast struct
// for the cursor array list; no dependencies
package cal_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int WORD_W   = 32;
  localparam int FIELD_W  = 7;
  localparam int KIND_W   = 4;

  typedef enum logic [KIND_W-1:0] {
    KIND_CLEAR  = 4'd0,
    KIND_START  = 4'd1,
    KIND_END    = 4'd2,
    KIND_PREV   = 4'd3,
    KIND_NEXT   = 4'd4,
    KIND_SETPOS = 4'd5,
    KIND_READ   = 4'd6,
    KIND_INSERT = 4'd7,
    KIND_APPEND = 4'd8,
    KIND_REMOVE = 4'd9
  } kind_t;

  typedef enum logic [1:0] {
    SH_HOLD,
    SH_INSERT,
    SH_APPEND,
    SH_REMOVE
  } shift_op_t;

  typedef struct packed {
    shift_op_t                op;
    logic [CNT_W-1:0]         cursor;
    logic [CNT_W-1:0]         count;
    logic signed [WORD_W-1:0] item;
  } cal_bcast_t;

endpackage

// ===== hdl/cal_cell.sv =====
// cal_cell: one list slot, holds a word and trades it with its neighbors
// depends on cal_pkg
module cal_cell (
  input  logic                              clk,
  input  logic [cal_pkg::IDX_W-1:0]         cell_idx,
  input  cal_pkg::cal_bcast_t               bcast,
  input  logic signed [cal_pkg::WORD_W-1:0] lower_val,
  input  logic signed [cal_pkg::WORD_W-1:0] upper_val,
  output logic signed [cal_pkg::WORD_W-1:0] cell_val,
  output logic signed [cal_pkg::WORD_W-1:0] hit_val
);
  import cal_pkg::*;

  logic signed [WORD_W-1:0] value_r;
  logic signed [WORD_W-1:0] value_nxt;
  logic [CNT_W-1:0]         idx_ext;

  assign idx_ext  = CNT_W'(cell_idx);
  assign cell_val = value_r;
  // word at the cursor, zero elsewhere so the top can or them together
  assign hit_val  = (idx_ext == bcast.cursor) ? value_r : '0;

  always_comb begin
    value_nxt = value_r;
    case (bcast.op)
      SH_INSERT: begin
        if (idx_ext > bcast.cursor) begin
          value_nxt = lower_val;
        end else if (idx_ext == bcast.cursor) begin
          value_nxt = bcast.item;
        end
      end
      SH_APPEND: begin
        if (idx_ext == bcast.count) begin
          value_nxt = bcast.item;
        end
      end
      SH_REMOVE: begin
        if (idx_ext >= bcast.cursor) begin
          value_nxt = upper_val;
        end
      end
      default: value_nxt = value_r;
    endcase
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

endmodule

// ===== hdl/cursor_array_list.sv =====
// cursor_array_list: top level, request decode, cursor and length registers,
// the row of cal_cell slots and the registered result; depends on cal_pkg, cal_cell
//
// timing: out_valid is registered from the accepted request, so the result strobe comes in the cycle after it
// throughput: one request per cycle, busy stays low; every slot shifts in the
//   same cycle, the read word comes from an or over the row of slots
// reset (rst_n low, synchronous): length 0, cursor 0, list_limit 64, no result;
//   stored words are not cleared. results cannot be stalled by the receiver
module cursor_array_list (
  input  logic                              clk,
  input  logic                              rst_n,
  // request channel
  input  logic                              start,
  output logic                              busy,
  input  logic [cal_pkg::KIND_W-1:0]        in_kind,
  input  logic signed [cal_pkg::WORD_W-1:0] in_item_value,
  input  logic [cal_pkg::FIELD_W-1:0]       in_position,
  // result channel
  output logic                              out_valid,
  output logic                              out_ok,
  output logic signed [cal_pkg::WORD_W-1:0] out_data_value,
  output logic [cal_pkg::FIELD_W-1:0]       out_cursor_now,
  output logic [cal_pkg::FIELD_W-1:0]       out_length_now,
  // configuration channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [cal_pkg::FIELD_W-1:0]       cfg_list_limit
);
  import cal_pkg::*;

  // control state
  logic [CNT_W-1:0]   cursor_r, cursor_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [FIELD_W-1:0] list_limit_r;

  // result registers
  logic                     out_valid_r;
  logic                     out_ok_r, out_ok_nxt;
  logic signed [WORD_W-1:0] out_data_r, out_data_nxt;
  logic [FIELD_W-1:0]       out_cursor_r;
  logic [FIELD_W-1:0]       out_length_r;

  logic                     req_go;
  logic [CNT_W-1:0]         limit_act;
  logic [CNT_W-1:0]         count_dec;
  logic signed [WORD_W-1:0] cursor_word;
  cal_bcast_t               bcast;

  logic signed [WORD_W-1:0] cell_val [CAPACITY];
  logic signed [WORD_W-1:0] hit_val  [CAPACITY];

  // one request per cycle, nothing ever holds the sender off
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign req_go    = start & ~busy;

  // limit in force is the smaller of the register and the built capacity
  always_comb begin
    if (int'(list_limit_r) < CAPACITY) begin
      limit_act = CNT_W'(list_limit_r);
    end else begin
      limit_act = CNT_W'(CAPACITY);
    end
  end

  assign count_dec = count_r - CNT_W'(1);

  // word at the cursor: each slot drives zero unless it sits at the cursor
  always_comb begin
    cursor_word = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      cursor_word = cursor_word | hit_val[i];
    end
  end

  // request decode: new cursor, new length, result and the shift command
  always_comb begin
    cursor_nxt   = cursor_r;
    count_nxt    = count_r;
    out_ok_nxt   = 1'b0;
    out_data_nxt = '0;
    bcast.op     = SH_HOLD;
    bcast.cursor = cursor_r;
    bcast.count  = count_r;
    bcast.item   = in_item_value;
    if (req_go) begin
      case (kind_t'(in_kind))
        KIND_CLEAR: begin
          cursor_nxt = '0;
          count_nxt  = '0;
          out_ok_nxt = 1'b1;
        end
        KIND_START: begin
          cursor_nxt = '0;
          out_ok_nxt = 1'b1;
        end
        KIND_END: begin
          cursor_nxt = count_r;
          out_ok_nxt = 1'b1;
        end
        KIND_PREV: begin
          if (cursor_r != '0) begin
            cursor_nxt = cursor_r - CNT_W'(1);
          end
          out_ok_nxt = 1'b1;
        end
        KIND_NEXT: begin
          if (cursor_r < count_r) begin
            cursor_nxt = cursor_r + CNT_W'(1);
          end
          out_ok_nxt = 1'b1;
        end
        KIND_SETPOS: begin
          // compare at the port width so large positions are refused
          if (in_position <= FIELD_W'(count_r)) begin
            cursor_nxt = CNT_W'(in_position);
            out_ok_nxt = 1'b1;
          end
        end
        KIND_READ: begin
          if (cursor_r < count_r) begin
            out_data_nxt = cursor_word;
            out_ok_nxt   = 1'b1;
          end
        end
        KIND_INSERT: begin
          if (count_r < limit_act) begin
            bcast.op   = SH_INSERT;
            count_nxt  = count_r + CNT_W'(1);
            out_ok_nxt = 1'b1;
          end
        end
        KIND_APPEND: begin
          if (count_r < limit_act) begin
            bcast.op   = SH_APPEND;
            count_nxt  = count_r + CNT_W'(1);
            out_ok_nxt = 1'b1;
          end
        end
        KIND_REMOVE: begin
          if (cursor_r < count_r) begin
            bcast.op     = SH_REMOVE;
            out_data_nxt = cursor_word;
            count_nxt    = count_dec;
            // removing the tail word pulls the cursor back to the new end
            if (cursor_r > count_dec) begin
              cursor_nxt = count_dec;
            end
            out_ok_nxt = 1'b1;
          end
        end
        default: begin
          // unknown kinds change nothing and are refused
          out_ok_nxt = 1'b0;
        end
      endcase
    end
  end

  // row of slots, each swaps with its neighbors on insert and remove
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [WORD_W-1:0] lower_w;
    logic signed [WORD_W-1:0] upper_w;

    if (g == 0) begin : g_first
      assign lower_w = '0;
    end else begin : g_lower
      assign lower_w = cell_val[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign upper_w = '0;
    end else begin : g_upper
      assign upper_w = cell_val[g+1];
    end

    cal_cell u_cell (
      .clk       (clk),
      .cell_idx  (IDX_W'(g)),
      .bcast     (bcast),
      .lower_val (lower_w),
      .upper_val (upper_w),
      .cell_val  (cell_val[g]),
      .hit_val   (hit_val[g])
    );
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r     <= '0;
      count_r      <= '0;
      list_limit_r <= FIELD_W'(CAPACITY < 64 ? CAPACITY : 64);
      out_valid_r  <= 1'b0;
    end else begin
      cursor_r    <= cursor_nxt;
      count_r     <= count_nxt;
      out_valid_r <= req_go;
      if (cfg_valid && cfg_ready) begin
        list_limit_r <= cfg_list_limit;
      end
    end
  end

  // result payload, qualified by out_valid
  always_ff @(posedge clk) begin
    out_ok_r     <= out_ok_nxt;
    out_data_r   <= out_data_nxt;
    out_cursor_r <= FIELD_W'(cursor_nxt);
    out_length_r <= FIELD_W'(count_nxt);
  end

  assign out_valid      = out_valid_r;
  assign out_ok         = out_ok_r;
  assign out_data_value = out_data_r;
  assign out_cursor_now = out_cursor_r;
  assign out_length_now = out_length_r;

endmodule
